[design/ks_pkg.sv]
// Shared types, sizes and helpers for the keyed slot table.
package ks_pkg;

  localparam int TABLE_SLOTS = 1024;
  localparam int SLOT_W = $clog2(TABLE_SLOTS);
  localparam int CNT_W = SLOT_W + 1;
  localparam int KEY_W = 31;
  localparam int VAL_W = 31;
  localparam int IDX_W = 10;
  localparam int ENTRY_W = KEY_W + 1;

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [KEY_W-1:0] key_t;
  typedef logic [VAL_W-1:0] val_t;
  typedef logic [IDX_W-1:0] idx_t;

  typedef enum logic [1:0] {
    ACT_INSERT     = 2'd0,
    ACT_DELETE     = 2'd1,
    ACT_UPD_FIRST  = 2'd2,
    ACT_UPD_SECOND = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    STAT_DONE      = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_FULL      = 2'd2
  } status_t;

  typedef struct packed {
    action_t action;
    key_t    key;
    val_t    first_value;
    val_t    second_value;
  } req_t;

  typedef struct packed {
    status_t status;
    idx_t    slot_index;
  } rsp_t;

  typedef struct packed {
    logic valid;
    key_t key;
  } entry_t;

  typedef struct packed {
    logic   entry_we;
    logic   first_we;
    logic   second_we;
    slot_t  waddr;
    entry_t entry;
    val_t   first_value;
    val_t   second_value;
  } mem_cmd_t;

  function automatic idx_t to_index(slot_t s);
    logic [IDX_W+SLOT_W-1:0] w;
    w = {{IDX_W{1'b0}}, s};
    return w[IDX_W-1:0];
  endfunction

endpackage

[design/ks_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module ks_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/ks_match.sv]
// Slot compare unit: free-slot test for insert, key match for the others.
module ks_match (
  input  ks_pkg::action_t action,
  input  ks_pkg::key_t    key,
  input  ks_pkg::entry_t  entry,
  output logic            hit
);
  import ks_pkg::*;

  always_comb begin
    if (action == ACT_INSERT) begin
      hit = !entry.valid;
    end else begin
      hit = entry.valid && (entry.key == key);
    end
  end

endmodule

[design/ks_ctrl.sv]
// Scan sequencer: clearing pass, slot scan, table write and result register.
module ks_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  ks_pkg::req_t      req,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output ks_pkg::rsp_t      rsp,
  output ks_pkg::slot_t     rd_addr,
  input  ks_pkg::entry_t    rd_entry,
  output ks_pkg::mem_cmd_t  cmd
);
  import ks_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_SCAN  = 4'b0100,
    S_STORE = 4'b1000
  } state_t;

  state_t state, state_next;
  req_t   req_q;
  slot_t  clr;
  cnt_t   rd_cnt;
  logic   cmp_live;
  slot_t  cmp_slot;
  logic   found;
  slot_t  hit_slot;
  logic   hit;
  logic   scan_end;
  logic   rsp_load;
  logic   all_read;

  ks_match u_match (
    .action (req_q.action),
    .key    (req_q.key),
    .entry  (rd_entry),
    .hit    (hit)
  );

  assign req_ready = (state == S_IDLE);
  assign rd_addr = rd_cnt[SLOT_W-1:0];
  assign all_read = (rd_cnt == CNT_W'(TABLE_SLOTS));
  assign scan_end = (cmp_live && hit) || (!cmp_live && all_read);
  assign rsp_load = (state == S_STORE) && (!rsp_valid || rsp_ready);

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clr == slot_t'(TABLE_SLOTS - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_end) begin
          state_next = S_STORE;
        end
      end
      S_STORE: begin
        if (rsp_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_comb begin
    cmd.entry_we     = 1'b0;
    cmd.first_we     = 1'b0;
    cmd.second_we    = 1'b0;
    cmd.waddr        = hit_slot;
    cmd.entry.valid  = (req_q.action == ACT_INSERT);
    cmd.entry.key    = req_q.key;
    cmd.first_value  = req_q.first_value;
    cmd.second_value = req_q.second_value;
    if (state == S_CLEAR) begin
      cmd.entry_we    = 1'b1;
      cmd.waddr       = clr;
      cmd.entry.valid = 1'b0;
    end else if (rsp_load && found) begin
      case (req_q.action)
        ACT_INSERT: begin
          cmd.entry_we  = 1'b1;
          cmd.first_we  = 1'b1;
          cmd.second_we = 1'b1;
        end
        ACT_DELETE:     cmd.entry_we  = 1'b1;
        ACT_UPD_FIRST:  cmd.first_we  = 1'b1;
        ACT_UPD_SECOND: cmd.second_we = 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr       <= '0;
      rd_cnt    <= '0;
      cmp_live  <= 1'b0;
      found     <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr <= clr + slot_t'(1);
      end
      if (state == S_IDLE && req_valid) begin
        req_q    <= req;
        rd_cnt   <= '0;
        cmp_live <= 1'b0;
        found    <= 1'b0;
      end
      if (state == S_SCAN) begin
        if (!all_read) begin
          rd_cnt   <= rd_cnt + cnt_t'(1);
          cmp_slot <= rd_cnt[SLOT_W-1:0];
          cmp_live <= 1'b1;
        end else begin
          cmp_live <= 1'b0;
        end
        if (cmp_live && hit) begin
          found    <= 1'b1;
          hit_slot <= cmp_slot;
        end
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
        if (found) begin
          rsp.status     <= STAT_DONE;
          rsp.slot_index <= to_index(hit_slot);
        end else begin
          rsp.status     <= (req_q.action == ACT_INSERT) ? STAT_FULL : STAT_NOT_FOUND;
          rsp.slot_index <= '0;
        end
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE || state == S_SCAN) |-> !(cmd.entry_we || cmd.first_we || cmd.second_we))
    else $error("table written outside clear or store");

  a_cmp_follows_read: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && cmp_live) |-> (CNT_W'(cmp_slot) + cnt_t'(1) == rd_cnt))
    else $error("compared slot out of step with read counter");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (rd_cnt <= CNT_W'(TABLE_SLOTS)))
    else $error("scan ran past the table");

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    rsp_load |=> (rsp_valid && state == S_IDLE))
    else $error("result load did not reach output");

  a_clear_done: assert property (@(posedge clk) disable iff (rst)
    ($past(state == S_CLEAR) && state == S_IDLE) |-> ($past(clr) == slot_t'(TABLE_SLOTS - 1)))
    else $error("clearing pass left early");

endmodule

[design/keyed_slot_table.sv]
// Keyed slot table top level: slot memories and scan sequencer.
//
//  channel  | handshake             | word
//  ---------+-----------------------+-------------------------------------------
//  request  | req_valid / req_ready | req: action, key, first_value, second_value
//  result   | rsp_valid / rsp_ready | rsp: status, slot_index
//
// The sequencer reads one slot per cycle from the key memory port and stops at
// the first hit. After reset a clearing pass writes every slot invalid, with
// req_ready low.
// A result waiting on rsp_ready holds the table write and the sequencer in store.
module keyed_slot_table (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  ks_pkg::req_t  req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output ks_pkg::rsp_t  rsp
);
  import ks_pkg::*;

  slot_t    rd_addr;
  entry_t   rd_entry;
  mem_cmd_t cmd;

  ks_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .rd_addr   (rd_addr),
    .rd_entry  (rd_entry),
    .cmd       (cmd)
  );

  ks_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_SLOTS)) u_entry_ram (
    .clk   (clk),
    .we    (cmd.entry_we),
    .waddr (cmd.waddr),
    .wdata (cmd.entry),
    .raddr (rd_addr),
    .rdata (rd_entry)
  );

  ks_ram #(.WIDTH(VAL_W), .DEPTH(TABLE_SLOTS)) u_first_ram (
    .clk   (clk),
    .we    (cmd.first_we),
    .waddr (cmd.waddr),
    .wdata (cmd.first_value),
    .raddr (rd_addr),
    .rdata ()
  );

  ks_ram #(.WIDTH(VAL_W), .DEPTH(TABLE_SLOTS)) u_second_ram (
    .clk   (clk),
    .we    (cmd.second_we),
    .waddr (cmd.waddr),
    .wdata (cmd.second_value),
    .raddr (rd_addr),
    .rdata ()
  );

endmodule

[sim/keyed_slot_table_test.sv]
`timescale 1ns / 1ps
// Self-checking bench for the keyed slot table: shadow table, directed and random requests.
module keyed_slot_table_test;
  import ks_pkg::*;

  class slot_table_board;
    bit   shadow_live[TABLE_SLOTS];
    key_t shadow_key[TABLE_SLOTS];
    val_t shadow_first[TABLE_SLOTS];
    val_t shadow_second[TABLE_SLOTS];
    rsp_t awaited_results[$];
    int   mismatches;
    int   results_seen;
    int   done_count;
    int   not_found_count;
    int   full_count;
    int   insert_count;
    int   delete_count;
    int   update_count;

    function new();
      for (int i = 0; i < TABLE_SLOTS; i++) shadow_live[i] = 1'b0;
      mismatches = 0;
      results_seen = 0;
      done_count = 0;
      not_found_count = 0;
      full_count = 0;
      insert_count = 0;
      delete_count = 0;
      update_count = 0;
    endfunction

    function int occupancy();
      int n;
      n = 0;
      for (int i = 0; i < TABLE_SLOTS; i++) n += shadow_live[i];
      return n;
    endfunction

    function int pending();
      return awaited_results.size();
    endfunction

    function void apply_request(req_t r);
      int   hit;
      rsp_t want;
      hit = -1;
      want.status = STAT_DONE;
      if (r.action == ACT_INSERT) begin
        insert_count++;
        for (int i = 0; i < TABLE_SLOTS; i++) begin
          if (!shadow_live[i]) begin
            hit = i;
            break;
          end
        end
        if (hit < 0) begin
          want.status = STAT_FULL;
        end else begin
          shadow_live[hit] = 1'b1;
          shadow_key[hit] = r.key;
          shadow_first[hit] = r.first_value;
          shadow_second[hit] = r.second_value;
        end
      end else begin
        if (r.action == ACT_DELETE) delete_count++;
        else update_count++;
        for (int i = 0; i < TABLE_SLOTS; i++) begin
          if (shadow_live[i] && shadow_key[i] == r.key) begin
            hit = i;
            break;
          end
        end
        if (hit < 0) begin
          want.status = STAT_NOT_FOUND;
        end else begin
          case (r.action)
            ACT_DELETE:    shadow_live[hit] = 1'b0;
            ACT_UPD_FIRST: shadow_first[hit] = r.first_value;
            default:       shadow_second[hit] = r.second_value;
          endcase
        end
      end
      want.slot_index = (want.status == STAT_DONE) ? idx_t'(hit) : '0;
      case (want.status)
        STAT_DONE:      done_count++;
        STAT_NOT_FOUND: not_found_count++;
        default:        full_count++;
      endcase
      awaited_results.push_back(want);
    endfunction

    function void check_result(rsp_t got);
      rsp_t want;
      results_seen++;
      if (awaited_results.size() == 0) begin
        $error("unexpected word: status %0d slot_index %0d", got.status, got.slot_index);
        mismatches++;
      end else begin
        want = awaited_results.pop_front();
        if (got.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, got.status);
          mismatches++;
        end
        if (got.slot_index !== want.slot_index) begin
          $error("slot_index: expected %0d, actual %0d", want.slot_index, got.slot_index);
          mismatches++;
        end
      end
    endfunction
  endclass

  localparam int CYCLE_LIMIT = 8_000_000;
  localparam int POOL_SIZE = 12;
  localparam int PHASE_ITEMS = 186;
  localparam int STALL_BURST = 400;
  localparam key_t KEY_MAX = {KEY_W{1'b1}};
  localparam val_t VAL_MAX = {VAL_W{1'b1}};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  slot_table_board board;
  key_t key_pool[POOL_SIZE];
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  int   stall_request = 0;
  int   cycle_count = 0;

  keyed_slot_table dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rsp_valid && rsp_ready) board.check_result(rsp);
  end

  initial begin
    int burst;
    @(posedge clk);
    forever begin
      if (stall_request != 0) begin
        burst = stall_request;
        stall_request = 0;
        rsp_ready <= 1'b0;
        repeat (burst) @(posedge clk);
      end else begin
        rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
      @(posedge clk);
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Simulation FAILED");
    $finish;
  end

  function automatic req_t make_request(action_t a, key_t k, val_t f, val_t s);
    req_t r;
    r.action = a;
    r.key = k;
    r.first_value = f;
    r.second_value = s;
    return r;
  endfunction

  function automatic req_t random_request();
    req_t r;
    int   pick;
    pick = $urandom_range(99);
    r.action = (pick < 30) ? ACT_INSERT : (pick < 60) ? ACT_DELETE :
               (pick < 80) ? ACT_UPD_FIRST : ACT_UPD_SECOND;
    // keep the table shallow so most scans stay short
    if (r.action == ACT_INSERT && board.occupancy() > 40) r.action = ACT_DELETE;
    r.key = ($urandom_range(99) < 75) ? key_pool[$urandom_range(POOL_SIZE - 1)]
                                      : key_t'($urandom);
    r.first_value = val_t'($urandom);
    r.second_value = val_t'($urandom);
    return r;
  endfunction

  // call right after clk rises; returns once the DUT has accepted the word
  task automatic send_request(req_t r);
    if ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    board.apply_request(r);
  endtask

  task automatic run_random(int count);
    for (int n = 0; n < count; n++) send_request(random_request());
  endtask

  initial begin
    board = new();
    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = key_t'($urandom);
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    send_request(make_request(ACT_UPD_FIRST, 31'd5, VAL_MAX, VAL_MAX));
    send_request(make_request(ACT_DELETE, 31'd5, '0, '0));
    send_request(make_request(ACT_UPD_SECOND, KEY_MAX, '0, VAL_MAX));
    send_request(make_request(ACT_INSERT, KEY_MAX, VAL_MAX, VAL_MAX));
    send_request(make_request(ACT_INSERT, 31'd1, '0, '0));
    send_request(make_request(ACT_INSERT, '0, 31'h2AAA_AAAA, 31'h5555_5555));
    send_request(make_request(ACT_INSERT, 31'd1, VAL_MAX, '0));
    send_request(make_request(ACT_UPD_FIRST, 31'd1, 31'h0123_4567, VAL_MAX));
    send_request(make_request(ACT_UPD_SECOND, 31'd1, VAL_MAX, 31'h7654_3210));
    send_request(make_request(ACT_DELETE, 31'd1, '0, '0));
    send_request(make_request(ACT_UPD_FIRST, 31'd1, 31'h5555_5555, '0));
    send_request(make_request(ACT_DELETE, 31'd1, '0, '0));
    send_request(make_request(ACT_UPD_SECOND, 31'd1, '0, 31'h2AAA_AAAA));
    send_request(make_request(ACT_DELETE, 31'd1, '0, '0));
    send_request(make_request(ACT_UPD_FIRST, '0, VAL_MAX, '0));
    send_request(make_request(ACT_DELETE, '0, '0, '0));
    send_request(make_request(ACT_INSERT, 31'd7, 31'h5555_5555, 31'h2AAA_AAAA));
    send_request(make_request(ACT_INSERT, 31'h5555_5555, '0, VAL_MAX));
    send_request(make_request(ACT_UPD_SECOND, KEY_MAX, VAL_MAX, '0));
    send_request(make_request(ACT_DELETE, KEY_MAX, '0, '0));
    send_request(make_request(ACT_DELETE, 31'd7, '0, '0));
    send_request(make_request(ACT_DELETE, 31'h5555_5555, '0, '0));

    send_idle_pct = 23;
    recv_idle_pct = 57;
    run_random(PHASE_ITEMS);
    send_idle_pct = 57;
    recv_idle_pct = 23;
    run_random(PHASE_ITEMS);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    // hold the result side while requests keep coming
    stall_request = STALL_BURST;
    run_random(PHASE_ITEMS);
    req_valid <= 1'b0;

    while (board.pending() != 0) @(posedge clk);
    repeat (TABLE_SLOTS + 16) @(posedge clk);

    $display("Covered %0d requests (%0d inserts, %0d deletes, %0d updates), %0d results",
             board.insert_count + board.delete_count + board.update_count,
             board.insert_count, board.delete_count, board.update_count,
             board.results_seen);
    $display("Statuses: %0d done, %0d key missing, %0d table full; %0d cycles, %0d mismatches",
             board.done_count, board.not_found_count, board.full_count, cycle_count,
             board.mismatches);
    if (board.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
